// ----- sv/window_distinct_counter_macros.svh -----
// Assertion macros shared by the window distinct counter modules.
`ifndef WINDOW_DISTINCT_COUNTER_MACROS_SVH
`define WINDOW_DISTINCT_COUNTER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WDC_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define WDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/wdc_pkg.sv -----
// Types, constants and codes for the window distinct counter.
`default_nettype none

package wdc_pkg;

	localparam int ARRAY_DEPTH_DEF = 1024;
	localparam int VALUE_RANGE_DEF = 1024;

	localparam int POS_W   = 10;
	localparam int VAL_W   = 10;
	localparam int END_W   = 11;
	localparam int COUNT_W = 11;

	// item op codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic              op;
		logic [POS_W-1:0]  position;
		logic [VAL_W-1:0]  value;
		logic [END_W-1:0]  range_end;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] distinct_count;
		logic               range_error;
	} result_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_STEP,
		ST_VAL,
		ST_UPD,
		ST_WOLD,
		ST_WDOWN,
		ST_WNEW,
		ST_WUP,
		ST_RESULT
	} state_t;

	typedef enum logic [2:0] {
		WALK_DONE,
		WALK_GROW_HI,
		WALK_GROW_LO,
		WALK_SHRINK_LO,
		WALK_SHRINK_HI
	} walk_t;

	typedef enum logic [1:0] {
		CNT_NONE,
		CNT_UP,
		CNT_DOWN,
		CNT_WALK
	} cnt_op_t;

	typedef struct packed {
		logic    clr;
		logic    load;
		logic    elem_rd;
		logic    walk_step;
		logic    elem_wr;
		logic    cnt_rd;
		logic    cnt_from_item;
		cnt_op_t cnt_op;
		logic    res_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic  is_query;
		logic  rev;
		logic  ignore;
		logic  in_window;
		walk_t walk;
		logic  clr_last;
	} dp_status_t;

endpackage

`default_nettype wire

// ----- sv/wdc_dpath.sv -----
// Datapath: item registers, window ends, element and count memories, result register.
`default_nettype none
`include "window_distinct_counter_macros.svh"

module wdc_dpath #(
	parameter int ARRAY_DEPTH = wdc_pkg::ARRAY_DEPTH_DEF,
	parameter int VALUE_RANGE = wdc_pkg::VALUE_RANGE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wdc_pkg::item_t      item,
	input  wdc_pkg::ctrl_cmd_t  cmd,
	output wdc_pkg::dp_status_t status,
	output wdc_pkg::result_t    result
);
	import wdc_pkg::*;

	localparam int AW    = $clog2(ARRAY_DEPTH);
	localparam int PW    = $clog2(ARRAY_DEPTH + 1);
	localparam int VW    = $clog2(VALUE_RANGE);
	localparam int CLR_N = (ARRAY_DEPTH > VALUE_RANGE) ? ARRAY_DEPTH : VALUE_RANGE;
	localparam int CLRW  = $clog2(CLR_N);

	logic [VW-1:0] elem_mem [ARRAY_DEPTH];
	logic [PW-1:0] cnt_mem  [VALUE_RANGE];

	logic          op_q;
	logic          rev_q;
	logic          ign_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] end_q;
	logic [VW-1:0] item_val_q;

	logic [PW-1:0]   low_q;
	logic [PW-1:0]   high_q;
	logic [PW-1:0]   total_q;
	logic [CLRW-1:0] clr_q;
	walk_t           dir_q;

	logic [VW-1:0] elem_rd_q;
	logic [PW-1:0] cnt_rd_q;
	logic [VW-1:0] cnt_addr_q;
	result_t       res_q;

	walk_t         walk;
	logic [PW-1:0] walk_idx;
	logic [AW-1:0] elem_ra;
	logic [AW-1:0] elem_wa;
	logic [VW-1:0] elem_wd;
	logic          elem_we;
	logic [VW-1:0] cnt_ra;
	logic [VW-1:0] cnt_wa;
	logic [PW-1:0] cnt_wd;
	logic          cnt_we;
	logic          cnt_upd;
	logic          cnt_up;
	logic          cnt_zero;
	logic          clr_elem;
	logic          clr_cnt;

	// Next step of the walk: grow before shrink so no count goes below zero.
	always_comb begin
		priority if (high_q < end_q) begin
			walk = WALK_GROW_HI;
		end else if (low_q > pos_q) begin
			walk = WALK_GROW_LO;
		end else if (low_q < pos_q) begin
			walk = WALK_SHRINK_LO;
		end else if (high_q > end_q) begin
			walk = WALK_SHRINK_HI;
		end else begin
			walk = WALK_DONE;
		end
	end

	always_comb begin
		unique case (walk)
			WALK_GROW_HI:   walk_idx = high_q;
			WALK_GROW_LO:   walk_idx = low_q - PW'(1);
			WALK_SHRINK_LO: walk_idx = low_q;
			WALK_SHRINK_HI: walk_idx = high_q - PW'(1);
			default:        walk_idx = low_q;
		endcase
	end

	assign status.is_query  = op_q;
	assign status.rev       = rev_q;
	assign status.ignore    = ign_q;
	assign status.in_window = (pos_q >= low_q) && (pos_q < high_q);
	assign status.walk      = walk;
	assign status.clr_last  = (clr_q == CLRW'(CLR_N - 1));

	// Item capture; query ends are clamped to the array here.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q       <= item.op;
			rev_q      <= item.range_end < {1'b0, item.position};
			ign_q      <= (32'(item.position) >= ARRAY_DEPTH) ||
			              (32'(item.value) >= VALUE_RANGE);
			pos_q      <= (32'(item.position) > ARRAY_DEPTH) ? PW'(ARRAY_DEPTH)
			                                                  : PW'(item.position);
			end_q      <= (32'(item.range_end) > ARRAY_DEPTH) ? PW'(ARRAY_DEPTH)
			                                                   : PW'(item.range_end);
			item_val_q <= VW'(item.value);
		end
		if (cmd.walk_step) begin
			dir_q <= walk;
		end
	end

	assign clr_elem = cmd.clr && (32'(clr_q) < ARRAY_DEPTH);
	assign clr_cnt  = cmd.clr && (32'(clr_q) < VALUE_RANGE);

	// Element store
	assign elem_ra = cmd.walk_step ? AW'(walk_idx) : AW'(pos_q);
	assign elem_we = clr_elem || cmd.elem_wr;
	assign elem_wa = cmd.clr ? AW'(clr_q) : AW'(pos_q);
	assign elem_wd = cmd.clr ? '0 : item_val_q;

	always_ff @(posedge clk) begin
		if (elem_we) begin
			elem_mem[elem_wa] <= elem_wd;
		end
		if (cmd.elem_rd) begin
			elem_rd_q <= elem_mem[elem_ra];
		end
	end

	// Count table: read, then modify and write back in a later cycle
	assign cnt_ra   = cmd.cnt_from_item ? item_val_q : elem_rd_q;
	assign cnt_upd  = (cmd.cnt_op != CNT_NONE);
	assign cnt_up   = (cmd.cnt_op == CNT_UP) ||
	                  ((cmd.cnt_op == CNT_WALK) &&
	                   ((dir_q == WALK_GROW_HI) || (dir_q == WALK_GROW_LO)));
	assign cnt_zero = (cnt_rd_q == '0);
	assign cnt_we   = clr_cnt || (cnt_upd && (cnt_up || !cnt_zero));
	assign cnt_wa   = cmd.clr ? VW'(clr_q) : cnt_addr_q;
	assign cnt_wd   = cmd.clr ? '0 : (cnt_up ? cnt_rd_q + PW'(1) : cnt_rd_q - PW'(1));

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (cmd.cnt_rd) begin
			cnt_rd_q   <= cnt_mem[cnt_ra];
			cnt_addr_q <= cnt_ra;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q   <= '0;
			high_q  <= '0;
			total_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + CLRW'(1);
			end
			if (cnt_upd) begin
				if (cnt_up && cnt_zero) begin
					total_q <= total_q + PW'(1);
				end else if (!cnt_up && (cnt_rd_q == PW'(1)) && (total_q != '0)) begin
					total_q <= total_q - PW'(1);
				end
			end
			if (cmd.cnt_op == CNT_WALK) begin
				unique case (dir_q)
					WALK_GROW_HI:   high_q <= high_q + PW'(1);
					WALK_GROW_LO:   low_q  <= low_q - PW'(1);
					WALK_SHRINK_LO: low_q  <= low_q + PW'(1);
					WALK_SHRINK_HI: high_q <= high_q - PW'(1);
					default:        ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q.distinct_count <= rev_q ? '0 : COUNT_W'(total_q);
			res_q.range_error    <= rev_q;
		end
	end

	assign result = res_q;

	`WDC_ASSERT_IMPLY(a_window_order, 1'b1, low_q <= high_q, "window ends crossed")
	`WDC_ASSERT_IMPLY(a_window_bound, 1'b1, high_q <= PW'(ARRAY_DEPTH), "window past array end")
	`WDC_ASSERT_IMPLY(a_total_bound, 1'b1, total_q <= high_q - low_q,
		"distinct total exceeds window size")

endmodule

`default_nettype wire

// ----- sv/wdc_ctrl.sv -----
// Controller: sequences clearing, writes and window walks, owns the handshakes.
`default_nettype none
`include "window_distinct_counter_macros.svh"

module wdc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	output logic                result_valid,
	input  logic                result_stall,
	input  wdc_pkg::dp_status_t status,
	output wdc_pkg::ctrl_cmd_t  cmd
);
	import wdc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				priority if (status.is_query) begin
					state_d = status.rev ? ST_RESULT : ST_STEP;
				end else if (status.ignore) begin
					state_d = ST_IDLE;
				end else if (status.in_window) begin
					cmd.elem_rd = 1'b1;
					state_d     = ST_WOLD;
				end else begin
					cmd.elem_wr = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			ST_STEP: begin
				if (status.walk == WALK_DONE) begin
					state_d = ST_RESULT;
				end else begin
					cmd.elem_rd   = 1'b1;
					cmd.walk_step = 1'b1;
					state_d       = ST_VAL;
				end
			end
			ST_VAL: begin
				cmd.cnt_rd = 1'b1;
				state_d    = ST_UPD;
			end
			ST_UPD: begin
				cmd.cnt_op = CNT_WALK;
				state_d    = ST_STEP;
			end
			// write inside the window: drop the old value, then add the new one
			ST_WOLD: begin
				cmd.cnt_rd = 1'b1;
				state_d    = ST_WDOWN;
			end
			ST_WDOWN: begin
				cmd.cnt_op = CNT_DOWN;
				state_d    = ST_WNEW;
			end
			ST_WNEW: begin
				cmd.cnt_rd        = 1'b1;
				cmd.cnt_from_item = 1'b1;
				state_d           = ST_WUP;
			end
			ST_WUP: begin
				cmd.cnt_op  = CNT_UP;
				cmd.elem_wr = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_RESULT: begin
				if (!result_valid_q || !result_stall) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;

	`WDC_ASSERT_NEXT(a_accept_decode, (state_q == ST_IDLE) && item_valid,
		state_q == ST_DECODE, "accepted item not decoded")
	`WDC_ASSERT_IMPLY(a_result_source, $rose(result_valid_q),
		$past(state_q == ST_RESULT), "result raised outside result state")
	`WDC_ASSERT_NEXT(a_result_hold, result_valid_q && result_stall, result_valid_q,
		"stalled result dropped")

endmodule

`default_nettype wire

// ----- sv/window_distinct_counter.sv -----
// Window distinct counter: element store with a sliding-window distinct-value count.
//
// Input channel (item, item_valid, item_stall): op 0 writes value at position,
// op 1 asks for the number of distinct values in [position, range_end).
// Output channel (result, result_valid, result_stall): one result per query,
// none per write. A reversed range gives range_error with a count of 0.
// A write in range stores the value; when the element lies in the window it also lowers
// the count of the old value and raises that of the new one. A query walks the window
// ends one element at a time; each step is a read of the element store followed by
// a read-modify-write of the count table. Query time thus depends on how far
// successive ranges lie apart; item_stall is high until an item is done.
// After reset both memories are cleared, one entry per cycle, over
// max(ARRAY_DEPTH, VALUE_RANGE) entries (1024 by default); item_stall is high
// during that pass. A finished result sits in an output register; while the
// receiver stalls it holds, and the block stops in its result state until the
// register frees, accepting no further item meanwhile.
`default_nettype none

module window_distinct_counter #(
	parameter int ARRAY_DEPTH = wdc_pkg::ARRAY_DEPTH_DEF,
	parameter int VALUE_RANGE = wdc_pkg::VALUE_RANGE_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  wdc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output wdc_pkg::result_t result
);
	import wdc_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	wdc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	wdc_dpath #(
		.ARRAY_DEPTH (ARRAY_DEPTH),
		.VALUE_RANGE (VALUE_RANGE)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule

`default_nettype wire

// ----- bench/wdc_count_check.sv -----
// Channel monitor for the window distinct counter: mirrors the window counts and checks results.
module wdc_count_check (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  wdc_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_stall,
	input  wdc_pkg::result_t result,
	output int               errors,
	output int               pending
);
	import wdc_pkg::*;

	localparam int  DEPTH    = ARRAY_DEPTH_DEF;
	localparam int  VALUES   = VALUE_RANGE_DEF;

	logic [VAL_W-1:0] elems [DEPTH];
	int unsigned      occur [VALUES];
	int unsigned      win_lo;
	int unsigned      win_hi;
	int unsigned      n_distinct;
	int               fails;
	result_t          counts_due [$];

	function automatic int unsigned elem_at(input int unsigned idx);
		return (idx < DEPTH) ? int'(elems[idx]) : 0;
	endfunction

	task automatic add_value(input int unsigned v);
		if (v < VALUES) begin
			occur[v]++;
			if (occur[v] == 1)
				n_distinct++;
		end
	endtask

	// a zero count stays at zero
	task automatic drop_value(input int unsigned v);
		if (v < VALUES && occur[v] != 0) begin
			occur[v]--;
			if (occur[v] == 0 && n_distinct > 0)
				n_distinct--;
		end
	endtask

	task automatic predict_distinct(input item_t it);
		int unsigned lo_tgt;
		int unsigned hi_tgt;
		result_t     r;
		lo_tgt = it.position;
		hi_tgt = it.range_end;
		if (it.op == OP_WRITE) begin
			if (lo_tgt < DEPTH && it.value < VALUES) begin
				if (lo_tgt >= win_lo && lo_tgt < win_hi) begin
					drop_value(elems[lo_tgt]);
					add_value(it.value);
				end
				elems[lo_tgt] = it.value;
			end
		end else if (hi_tgt < lo_tgt) begin
			// reversed range: flag only, window untouched
			r.distinct_count = '0;
			r.range_error    = 1'b1;
			counts_due.push_back(r);
		end else begin
			if (lo_tgt > DEPTH)
				lo_tgt = DEPTH;
			if (hi_tgt > DEPTH)
				hi_tgt = DEPTH;
			// grow before shrinking so no count goes negative
			while (win_hi < hi_tgt) begin
				add_value(elem_at(win_hi));
				win_hi++;
			end
			while (win_lo > lo_tgt) begin
				win_lo--;
				add_value(elem_at(win_lo));
			end
			while (win_lo < lo_tgt) begin
				drop_value(elem_at(win_lo));
				win_lo++;
			end
			while (win_hi > hi_tgt) begin
				win_hi--;
				drop_value(elem_at(win_hi));
			end
			r.distinct_count = n_distinct[COUNT_W-1:0];
			r.range_error    = 1'b0;
			counts_due.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			foreach (elems[i])
				elems[i] = '0;
			foreach (occur[i])
				occur[i] = 0;
			win_lo     = 0;
			win_hi     = 0;
			n_distinct = 0;
			fails      = 0;
			counts_due.delete();
		end else begin
			// retire the result first: it always belongs to an older item
			if (result_valid && !result_stall) begin
				if (counts_due.size() == 0) begin
					$error("result with no query waiting: distinct_count %0d, range_error %0b",
						result.distinct_count, result.range_error);
					fails++;
				end else begin
					want = counts_due.pop_front();
					if (result.distinct_count !== want.distinct_count) begin
						$error("distinct_count: expected %0d, actual %0d",
							want.distinct_count, result.distinct_count);
						fails++;
					end
					if (result.range_error !== want.range_error) begin
						$error("range_error: expected %0b, actual %0b",
							want.range_error, result.range_error);
						fails++;
					end
				end
			end
			if (item_valid && !item_stall)
				predict_distinct(item);
		end
		errors  <= fails;
		pending <= counts_due.size();
	end

endmodule

// ----- bench/testbench.sv -----
// Bench top for the window distinct counter: clock, reset, item stimulus and verdict.
module testbench;
	import wdc_pkg::*;

	localparam int   RAND_ITEMS = 950;
	localparam int   LIMIT      = 2_000_000;
	localparam int   TAIL       = 40;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;
	int      errors;
	int      pending;
	int      idle_pct     = 12;
	int      stall_pct    = 82;

	window_distinct_counter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	wdc_count_check u_watch (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.errors       (errors),
		.pending      (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// Called at a falling edge; returns at the falling edge after acceptance with valid still high.
	task automatic send(input logic kind, input int unsigned pos, input int unsigned val,
		input int unsigned rend);
		item_t nxt;
		nxt.op        = kind;
		nxt.position  = pos[POS_W-1:0];
		nxt.value     = val[VAL_W-1:0];
		nxt.range_end = rend[END_W-1:0];
		while ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= nxt;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("FAIL window_distinct_counter");
		$finish;
	end

	initial begin
		int unsigned lo;
		int unsigned hi;
		int unsigned pos;
		int unsigned rend;
		int unsigned val;
		int unsigned palette [8];

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed: empty and full ranges, clamping, reversed ranges, writes on window edges
		send(OP_QUERY, 0, 0, 0);
		send(OP_QUERY, 0, 0, 1024);
		send(OP_WRITE, 1023, 1023, 0);
		send(OP_WRITE, 0, 682, 2047);
		send(OP_WRITE, 5, 341, 0);
		send(OP_QUERY, 0, 1023, 2047);
		send(OP_QUERY, 1023, 0, 0);
		send(OP_QUERY, 6, 0, 5);
		send(OP_QUERY, 1023, 0, 1024);
		send(OP_QUERY, 0, 0, 16);
		send(OP_QUERY, 1023, 0, 1023);
		send(OP_WRITE, 1000, 7, 0);
		send(OP_QUERY, 990, 0, 1010);
		send(OP_WRITE, 1000, 7, 0);
		send(OP_WRITE, 1001, 7, 0);
		send(OP_WRITE, 990, 1023, 0);
		send(OP_WRITE, 1010, 5, 0);
		send(OP_QUERY, 1000, 0, 1002);
		send(OP_QUERY, 989, 0, 1011);
		send(OP_QUERY, 512, 0, 512);
		send(OP_QUERY, 0, 0, 1);
		send(OP_QUERY, 1023, 0, 2047);

		lo = 1023;
		hi = 1024;
		foreach (palette[k])
			palette[k] = $urandom_range(1023);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n == RAND_ITEMS / 3) begin
				idle_pct  = 82;
				stall_pct = 12;
			end
			if (n == 2 * RAND_ITEMS / 3) begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			if ($urandom_range(59) == 0)
				palette[$urandom_range(7)] = $urandom_range(1023);
			// small palette so values repeat inside a window
			val = ($urandom_range(6) == 0) ? $urandom_range(1023) : palette[$urandom_range(7)];

			if ($urandom_range(99) < 45) begin
				if ($urandom_range(7) == 0)
					pos = $urandom_range(1023);
				else
					pos = $urandom_range((hi + 4 > 1023) ? 1023 : hi + 4, (lo > 4) ? lo - 4 : 0);
				send(OP_WRITE, pos, val, $urandom_range(2047));
			end else begin
				case ($urandom_range(39))
					0: begin
						pos  = $urandom_range(1023);
						rend = pos + $urandom_range(64);
						if (rend > 1024)
							rend = 1024;
						lo = pos;
						hi = rend;
					end
					1, 2: begin
						// reversed: the window stays where it was
						pos  = $urandom_range(1023, 1);
						rend = $urandom_range(pos - 1);
					end
					3: begin
						pos  = $urandom_range(1023, 960);
						rend = $urandom_range(2047, 1025);
						lo   = pos;
						hi   = 1024;
					end
					default: begin
						pos = lo + $urandom_range(16);
						pos = (pos < 8) ? 0 : pos - 8;
						if (pos > 1023)
							pos = 1023;
						rend = pos + $urandom_range(48);
						if (rend > 1024)
							rend = 1024;
						lo = pos;
						hi = rend;
					end
				endcase
				send(OP_QUERY, pos, $urandom_range(1023), rend);
			end
		end
		item_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("PASS window_distinct_counter");
		else
			$display("FAIL window_distinct_counter");
		$finish;
	end

endmodule
